[rtl/core/mandelbrot_escape_time_defines.svh]
// ---------------------------------------------------------------------------
// Mandelbrot escape time: assertion macros
// Shared property forms for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define MBET_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define MBET_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/mbet_pkg.sv]
// ---------------------------------------------------------------------------
// Mandelbrot escape time: shared package
// Widths, constants, controller states and controller/datapath bundles.
// ---------------------------------------------------------------------------
package mbet_pkg;

  localparam int FRAC_BITS = 28;
  localparam int C_W       = 32;
  localparam int CNT_W     = 16;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  // Iterate width: holds c and any z with both parts within +/-2.
  localparam int ZW = (FRAC_BITS + 3 > C_W) ? FRAC_BITS + 3 : C_W;
  // Product width.
  localparam int PW = 2 * ZW;
  // Width of an updated part before the range check.
  localparam int NW = PW - FRAC_BITS + 2;
  // Width of the magnitude sum.
  localparam int MW = PW + 1;

  localparam logic signed [NW-1:0] Z_BOUND     = NW'(1) << (FRAC_BITS + 1);
  localparam logic signed [NW-1:0] Z_BOUND_NEG = -Z_BOUND;
  localparam logic [MW-1:0]        ESC_THRESH  = MW'(1) << (2 * FRAC_BITS + 2);

  localparam logic [CNT_W-1:0] LIMIT_RESET    = CNT_W'(1000);
  localparam logic             REG_ITER_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } mbet_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic step;
    logic finish;
    logic emit;
  } mbet_cmd_t;

  typedef struct packed {
    logic mag_escape;
    logic at_limit;
    logic range_escape;
    logic out_busy;
  } mbet_stat_t;

endpackage

[rtl/core/mbet_ctrl.sv]
// ---------------------------------------------------------------------------
// Mandelbrot escape time: controller
// Sequences load, multiply, update and result hand-off for one request.
// ---------------------------------------------------------------------------
module mbet_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 busy,
  input  mbet_pkg::mbet_stat_t stat,
  output mbet_pkg::mbet_cmd_t  cmd
);

  mbet_pkg::mbet_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbet_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      mbet_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = mbet_pkg::ST_MUL;
        end
      end
      mbet_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = mbet_pkg::ST_UPD;
      end
      mbet_pkg::ST_UPD: begin
        // finish on escape of the last iterate, on the limit, or on an
        // updated part that is already past 2
        if (stat.mag_escape || stat.at_limit || stat.range_escape) begin
          cmd.finish = 1'b1;
          state_next = mbet_pkg::ST_DONE;
        end else begin
          cmd.step   = 1'b1;
          state_next = mbet_pkg::ST_MUL;
        end
      end
      mbet_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = mbet_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mbet_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/mbet_dp.sv]
// ---------------------------------------------------------------------------
// Mandelbrot escape time: datapath
// Iterate registers, complex squaring unit, update, escape test, result.
// ---------------------------------------------------------------------------
module mbet_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  mbet_pkg::mbet_cmd_t             cmd,
  output mbet_pkg::mbet_stat_t            stat,
  input  logic [mbet_pkg::CNT_W-1:0]      iteration_limit,
  input  logic signed [mbet_pkg::C_W-1:0] c_real,
  input  logic signed [mbet_pkg::C_W-1:0] c_imag,
  input  logic                            point_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mbet_pkg::CNT_W-1:0]      escape_count,
  output logic                            result_last
);

  logic signed [mbet_pkg::ZW-1:0] zr, zi, cr, ci;
  logic signed [mbet_pkg::PW-1:0] rr, ii, ri, diff;
  logic signed [mbet_pkg::NW-1:0] nr, ni;
  logic [mbet_pkg::MW-1:0]        mag_sum;
  logic [mbet_pkg::CNT_W-1:0]     iter, res_count;
  logic                           pending, last_hold;
  logic                           nr_ok, ni_ok;

  // load c, then run z = z*z + c
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      zr        <= mbet_pkg::ZW'(c_real);
      zi        <= mbet_pkg::ZW'(c_imag);
      cr        <= mbet_pkg::ZW'(c_real);
      ci        <= mbet_pkg::ZW'(c_imag);
      iter      <= '0;
      pending   <= 1'b0;
      last_hold <= point_last;
    end else if (cmd.step) begin
      zr      <= mbet_pkg::ZW'(nr);
      zi      <= mbet_pkg::ZW'(ni);
      iter    <= iter + 1'b1;
      pending <= 1'b1;
    end
  end

  // squaring unit: three products of the current iterate
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rr <= mbet_pkg::PW'(zr) * mbet_pkg::PW'(zr);
      ii <= mbet_pkg::PW'(zi) * mbet_pkg::PW'(zi);
      ri <= mbet_pkg::PW'(zr) * mbet_pkg::PW'(zi);
    end
  end

  assign diff    = rr - ii;
  assign nr      = mbet_pkg::NW'(diff >>> mbet_pkg::FRAC_BITS) + mbet_pkg::NW'(cr);
  assign ni      = mbet_pkg::NW'(ri >>> (mbet_pkg::FRAC_BITS - 1)) + mbet_pkg::NW'(ci);
  assign mag_sum = {1'b0, rr} + {1'b0, ii};

  assign nr_ok = (nr <= mbet_pkg::Z_BOUND) && (nr >= mbet_pkg::Z_BOUND_NEG);
  assign ni_ok = (ni <= mbet_pkg::Z_BOUND) && (ni >= mbet_pkg::Z_BOUND_NEG);

  assign stat.mag_escape   = pending && (mag_sum > mbet_pkg::ESC_THRESH);
  assign stat.at_limit     = (iter == iteration_limit);
  assign stat.range_escape = !(nr_ok && ni_ok);
  assign stat.out_busy     = out_valid && out_stall;

  // the tested iterate came from the previous index
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (stat.mag_escape) begin
        res_count <= iter - 1'b1;
      end else if (stat.at_limit) begin
        res_count <= '0;
      end else begin
        res_count <= iter;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      escape_count <= res_count;
      result_last  <= last_hold;
    end
  end

endmodule

[rtl/core/mandelbrot_escape_time.sv]
// ---------------------------------------------------------------------------
// Mandelbrot escape time
// Escape-time counter for one complex point per request, with an APB
// register for the iteration limit.
// ---------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   --------------------   ---------------------------------
//   in        in_valid / in_stall    c_real, c_imag, point_last
//   out       out_valid / out_stall  escape_count, result_last
//   cfg       psel/penable/pwrite    paddr, pwdata, prdata (pready = 1)
//
// Each iteration runs the complex squaring unit (three 32x32 products),
// then updates z and tests the escape bound.
// A request stalls the input until its result moves to the output register;
// it runs at most iteration_limit iterations, fewer on an escape or when a part passes 2.
// Reset is synchronous on rst: controller to idle, output empty, limit 1000.
// A finished result waits in the output register while the next request
// is accepted; a stalled output holds only the final hand-off.
// ---------------------------------------------------------------------------
`include "mandelbrot_escape_time_defines.svh"

module mandelbrot_escape_time (
  input  logic                               clk,
  input  logic                               rst,
  // point requests
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [mbet_pkg::C_W-1:0]    c_real,
  input  logic signed [mbet_pkg::C_W-1:0]    c_imag,
  input  logic                               point_last,
  // results
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mbet_pkg::CNT_W-1:0]         escape_count,
  output logic                               result_last,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mbet_pkg::ADDR_W-1:0]        paddr,
  input  logic [mbet_pkg::DATA_W-1:0]        pwdata,
  output logic [mbet_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  logic [mbet_pkg::CNT_W-1:0] iteration_limit;
  logic                       cfg_write;
  mbet_pkg::mbet_cmd_t        cmd;
  mbet_pkg::mbet_stat_t       stat;

  // Register file: one register, word index taken from paddr[2].
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_limit <= mbet_pkg::LIMIT_RESET;
    end else if (cfg_write && (paddr[2] == mbet_pkg::REG_ITER_LIMIT)) begin
      iteration_limit <= pwdata[mbet_pkg::CNT_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      mbet_pkg::REG_ITER_LIMIT: prdata = mbet_pkg::DATA_W'(iteration_limit);
      default:                  prdata = '0;
    endcase
  end

  // Controller: drop stall only while idle.
  mbet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .busy     (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: iterate, squaring unit, escape test, output register.
  mbet_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .iteration_limit (iteration_limit),
    .c_real          (c_real),
    .c_imag          (c_imag),
    .point_last      (point_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .escape_count    (escape_count),
    .result_last     (result_last)
  );

  // An accepted request keeps the block busy in the next cycle.
  `MBET_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "busy lost after accept")

  // A count is either zero or an index below the limit.
  `MBET_ASSERT_IMP(a_count_below_limit, out_valid, (escape_count == '0) || (escape_count < iteration_limit), "count not below limit")

  // A new result appears only after a request was in work.
  `MBET_ASSERT_IMP(a_result_from_request, $rose(out_valid), $past(in_stall), "result without request")

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Mandelbrot escape time: testbench
// Sends complex points through the request channel and checks each escape
// count and batch flag against an exact fixed-point model of the iteration.
// Steps through several iteration limits over the register port, including
// zero, one and the full 16-bit range.
// ---------------------------------------------------------------------------
module tb;
  import mbet_pkg::*;

  // one point as sent, with an optional hand-computed count
  typedef struct {
    logic signed [C_W-1:0] re;
    logic signed [C_W-1:0] im;
    logic                  last;
    bit                    known;
    logic [CNT_W-1:0]      count;
  } point_row_t;

  // one result as it should come back
  typedef struct {
    logic [CNT_W-1:0] count;
    logic             last;
  } escape_result_t;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_LONG
  } stall_mode_t;

  localparam logic [ADDR_W-1:0]     LIMIT_ADDR   = ADDR_W'(int'(REG_ITER_LIMIT) * 4);
  localparam logic signed [127:0]   S64_MAX      = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0]   S64_MIN      = -S64_MAX - 128'sd1;
  // |z|^2 > 4, with 2*FRAC_BITS fraction bits in the squared magnitude
  localparam logic [127:0]          ESCAPE_BOUND = 128'd1 << (2 * FRAC_BITS + 2);
  localparam int                    NUM_PHASES   = 7;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [C_W-1:0]     c_real;
  logic signed [C_W-1:0]     c_imag;
  logic                      point_last;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [CNT_W-1:0]          escape_count;
  logic                      result_last;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ADDR_W-1:0]         paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;

  // predictor copy of the iteration limit register
  logic [CNT_W-1:0]          limit_now;
  escape_result_t            expected_results[$];
  point_row_t                directed_points[$];
  escape_result_t            got_want;
  int                        errors = 0;
  int                        burst_left = 0;
  int                        phase_items[NUM_PHASES] = '{40, 40, 60, 120, 120, 80, 140};

  stall_mode_t               stall_mode = STALL_NONE;
  int                        mode_left = 0;
  int                        hold_left = 0;

  mandelbrot_escape_time u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .c_real       (c_real),
    .c_imag       (c_imag),
    .point_last   (point_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .escape_count (escape_count),
    .result_last  (result_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  // Clamp to the signed 64-bit range of one part of z.
  function automatic logic signed [127:0] clamp64(input logic signed [127:0] v);
    if (v > S64_MAX) return S64_MAX;
    if (v < S64_MIN) return S64_MIN;
    return v;
  endfunction

  // Run z = z*z + c from z = c and return the first iteration index whose
  // result lies strictly outside radius 2; 0 when none does within the limit.
  function automatic logic [CNT_W-1:0] escape_index(input logic signed [C_W-1:0] cr,
                                                    input logic signed [C_W-1:0] ci,
                                                    input logic [CNT_W-1:0] limit);
    logic signed [127:0] zr;
    logic signed [127:0] zi;
    logic signed [127:0] rr;
    logic signed [127:0] ii;
    logic signed [127:0] ri;
    logic [127:0]        mag;
    logic [CNT_W-1:0]    count;
    int unsigned         j;
    zr = 128'(cr);
    zi = 128'(ci);
    count = '0;
    for (j = 0; j < limit; j++) begin
      // products are exact in 128 bits; the shifts floor toward minus infinity
      rr = zr * zr;
      ii = zi * zi;
      ri = zr * zi;
      zr = clamp64(clamp64((rr - ii) >>> FRAC_BITS) + 128'(cr));
      zi = clamp64(clamp64(ri >>> (FRAC_BITS - 1)) + 128'(ci));
      // the sum of squares can reach 2^127, so compare it unsigned
      mag = zr * zr + zi * zi;
      if (mag > ESCAPE_BOUND) begin
        count = j[CNT_W-1:0];
        break;
      end
    end
    return count;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  function automatic int to_fixed(input real x);
    return $rtoi(x * (2.0 ** FRAC_BITS));
  endfunction

  // Mostly points around the set, where the counts spread out; some from
  // the full input range, which escape at once; some near the boundary of
  // the set, where counts run long.
  function automatic point_row_t random_point();
    point_row_t p;
    int         pick;
    pick = $urandom_range(0, 9);
    p.known = 1'b0;
    p.count = '0;
    p.last = ($urandom_range(0, 7) == 0);
    if (pick < 2) begin
      p.re = $urandom;
      p.im = $urandom;
    end else if (pick < 8) begin
      p.re = to_fixed(-2.25) + $urandom_range(0, to_fixed(3.0));
      p.im = to_fixed(-1.5) + $urandom_range(0, to_fixed(3.0));
    end else begin
      p.re = to_fixed(-0.8) + $urandom_range(0, to_fixed(0.1));
      p.im = $urandom_range(0, to_fixed(0.2));
      if ($urandom_range(0, 1) == 0) p.im = -p.im;
    end
    return p;
  endfunction

  // Send one point in bursts with random gaps, and log its expected result
  // at the edge where the request is taken.
  task automatic send_point(input point_row_t row);
    escape_result_t want;
    int             gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    c_real     <= row.re;
    c_imag     <= row.im;
    point_last <= row.last;
    do @(posedge clk); while (in_stall);
    want.count = row.known ? row.count : escape_index(row.re, row.im, limit_now);
    want.last  = row.last;
    expected_results.push_back(want);
  endtask

  // Drop the request line and wait until every result is back.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the iteration limit, then read it back. Upper data bits carry
  // noise, which the register drops.
  task automatic program_limit(input logic [CNT_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= {16'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    limit_now = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CNT_W-1:0] !== value) begin
      $error("iteration_limit: expected %0d, got %0d", value, prdata[CNT_W-1:0]);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Output side: stall on a pattern of its own, check every taken result
  // -------------------------------------------------------------------------

  // Switch between no stall, scattered stalls and long stall runs.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      mode_left  = $urandom_range(32, 256);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end
      default: begin
        if (hold_left == 0) begin
          hold_left = $urandom_range(1, 12);
          out_stall <= ~out_stall;
        end
        hold_left--;
      end
    endcase
  end

  // Compare each result taken off the output with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("escape_count: no result expected, got %0d", escape_count);
        errors++;
      end else begin
        got_want = expected_results.pop_front();
        if (escape_count !== got_want.count) begin
          $error("escape_count: expected %0d, got %0d", got_want.count, escape_count);
          errors++;
        end
        if (result_last !== got_want.last) begin
          $error("result_last: expected %0b, got %0b", got_want.last, result_last);
          errors++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    logic [CNT_W-1:0] lim;
    rst        = 1'b1;
    in_valid   = 1'b0;
    c_real     = '0;
    c_imag     = '0;
    point_last = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    limit_now  = LIMIT_RESET;

    // Directed points, run at the reset limit. Counts are typed in where
    // the orbit is easy to follow by hand.
    // origin: fixed point, never escapes
    directed_points.push_back(point_row_t'{0, 0, 1'b0, 1'b1, 16'd0});
    // -2: orbit sits at 2, exactly on the bound, never counted as escaped
    directed_points.push_back(point_row_t'{to_fixed(-2.0), 0, 1'b0, 1'b1, 16'd0});
    // 1: z goes 2, then 5
    directed_points.push_back(point_row_t'{to_fixed(1.0), 0, 1'b1, 1'b1, 16'd1});
    // 0.5: z goes 0.75, 1.0625, 1.6289, 3.1533
    directed_points.push_back(point_row_t'{to_fixed(0.5), 0, 1'b0, 1'b1, 16'd3});
    // period-two orbits, never escape
    directed_points.push_back(point_row_t'{to_fixed(-1.0), 0, 1'b0, 1'b1, 16'd0});
    directed_points.push_back(point_row_t'{0, to_fixed(1.0), 1'b0, 1'b1, 16'd0});
    // field extremes: gone at the first iteration, same count as no escape
    directed_points.push_back(point_row_t'{32'sh8000_0000, 32'sh8000_0000, 1'b1, 1'b1, 16'd0});
    directed_points.push_back(point_row_t'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 1'b1, 16'd0});
    directed_points.push_back(point_row_t'{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 1'b1, 16'd0});
    directed_points.push_back(point_row_t'{32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 1'b1, 16'd0});
    directed_points.push_back(point_row_t'{0, 32'sh8000_0000, 1'b0, 1'b1, 16'd0});
    // the rest go through the predictor
    directed_points.push_back(point_row_t'{to_fixed(0.25), 0, 1'b0, 1'b0, 16'd0});
    directed_points.push_back(point_row_t'{to_fixed(0.26), 0, 1'b0, 1'b0, 16'd0});
    directed_points.push_back(point_row_t'{to_fixed(-0.75), to_fixed(0.1), 1'b0, 1'b0, 16'd0});
    directed_points.push_back(point_row_t'{to_fixed(0.3), to_fixed(0.5), 1'b1, 1'b0, 16'd0});
    directed_points.push_back(point_row_t'{to_fixed(-1.25), to_fixed(0.1), 1'b0, 1'b0, 16'd0});
    directed_points.push_back(point_row_t'{to_fixed(-0.1), to_fixed(0.65), 1'b0, 1'b0, 16'd0});
    directed_points.push_back(point_row_t'{to_fixed(0.28), to_fixed(-0.53), 1'b0, 1'b0, 16'd0});
    directed_points.push_back(point_row_t'{to_fixed(-1.76), to_fixed(0.01), 1'b1, 1'b0, 16'd0});

    // hold reset, then release it on a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_points[k]) send_point(directed_points[k]);
    wait_idle();

    // Random phases: zero, one and two iterations, a short and a longer random
    // limit, the reset value, then 64; each limit is written only with the block idle.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       lim = '0;
        1:       lim = CNT_W'(1);
        2:       lim = CNT_W'(2);
        3:       lim = CNT_W'($urandom_range(3, 40));
        4:       lim = CNT_W'($urandom_range(41, 400));
        5:       lim = LIMIT_RESET;
        default: lim = CNT_W'(64);
      endcase
      program_limit(lim);
      repeat (phase_items[ph]) send_point(random_point());
      wait_idle();
    end

    // Full 16-bit limit: one point that runs every iteration, two that leave.
    program_limit('1);
    send_point(point_row_t'{0, 0, 1'b0, 1'b1, 16'd0});
    send_point(point_row_t'{to_fixed(1.0), 0, 1'b0, 1'b1, 16'd1});
    send_point(point_row_t'{to_fixed(0.26), 0, 1'b1, 1'b0, 16'd0});
    wait_idle();

    // let any stray result show up before the verdict
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("mandelbrot_escape_time test passed");
    end else begin
      $display("mandelbrot_escape_time test failed");
    end
    $finish;
  end

  // watchdog, well past the slowest correct run
  initial begin
    #10_000_000;
    $display("mandelbrot_escape_time test failed");
    $finish;
  end

endmodule
